// File: rtl/edv_pkg.sv
// Shared constants, types and helpers for the encoder distance/velocity core.
package edv_pkg;

  // Operand and product widths of the serial arithmetic
  localparam int MAG_W      = 33;              // magnitude of a 33-bit signed value
  localparam int FACT_W     = 16;              // second multiplier factor, divisor
  localparam int PROD_W     = 50;              // MAG_W + FACT_W, padded to even
  localparam int MUL_DIGIT  = 4;               // factor bits consumed per cycle
  localparam int MUL_STEPS  = FACT_W / MUL_DIGIT;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int DIV_RADIX  = 2;               // quotient bits produced per cycle
  localparam int DIV_STEPS  = PROD_W / DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FACT_W-1:0] MS_PER_SECOND = FACT_W'(1000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIRCUMFERENCE = 2'd0,
    REG_PULSES        = 2'd1
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic {
    MODE_EDGE   = 1'b0,
    MODE_UPDATE = 1'b1
  } item_mode_t;

  // Update sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST_MUL,
    ST_DIST_DIV,
    ST_VEL_LOAD,
    ST_VEL_MUL,
    ST_VEL_DIV,
    ST_HOLD
  } seq_state_t;

  // Saturate a sign and magnitude pair to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic neg,
                                               input logic [PROD_W-1:0] mag);
    logic signed [31:0] r;
    if (!neg) begin
      if (mag > PROD_W'(32'h7fff_ffff)) r = 32'sh7fff_ffff;
      else r = mag[31:0];
    end else begin
      if (mag > PROD_W'(33'h0_8000_0000)) r = 32'sh8000_0000;
      else r = -mag[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/encoder_distance_velocity_core.sv
// Top level: x1 quadrature step counter with serial distance and velocity math.
// An edge beat, taken whenever the block is idle, updates the signed step count;
// it gives no result. An update beat stalls the input until the sequencer is
// idle again: distance = circumference * steps / pulses, then velocity =
// (distance - last distance) * 1000 / elapsed_ms, each as a multiply of four
// 4-bit digit steps and a restoring divide of 25 two-bit steps, with a load
// state between the two halves and a hold state that hands the result to the
// output register. Both run in sign-magnitude form so that the quotients
// truncate toward zero and then saturate to signed 32 bits. A zero divisor is
// taken as one. The result sits in an output register, so the next beat is
// taken while it waits; a second update then waits at its end until the
// register is free. Configuration writes are always ready and must arrive
// only while the block is idle.
module encoder_distance_velocity_core (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [edv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [edv_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic                            pin_a_level,
  input  logic                            pin_b_level,
  input  logic [15:0]                     elapsed_ms,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              distance_out,
  output logic signed [31:0]              velocity_out
);
  import edv_pkg::*;

  seq_state_t          state, state_next;
  logic [15:0]         circumference;
  logic [15:0]         pulses;
  logic [15:0]         dt;
  logic signed [31:0]  step_count;
  logic signed [31:0]  last_distance;
  logic signed [31:0]  distance;
  logic signed [31:0]  vel;
  logic                neg;

  logic                in_accept;
  logic                slot_free;
  logic                mul_start, mul_done;
  logic                div_start, div_done;
  logic [MAG_W-1:0]    mul_a;
  logic [FACT_W-1:0]   mul_b;
  logic [FACT_W-1:0]   div_d;
  logic [PROD_W-1:0]   product, quotient;
  logic                neg_load;
  logic                neg_value;
  logic [MAG_W-1:0]    steps_ext, steps_mag;
  logic [MAG_W-1:0]    diff, diff_mag;
  logic [15:0]         pulses_eff, dt_eff;

  assign in_accept  = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign slot_free  = !out_valid || !out_stall;
  assign pulses_eff = (pulses == '0) ? 16'd1 : pulses;
  assign dt_eff     = (dt == '0) ? 16'd1 : dt;

  // Sign and magnitude of the step count and of the distance change
  assign steps_ext = {step_count[31], step_count};
  assign steps_mag = step_count[31] ? (~steps_ext + 1'b1) : steps_ext;
  assign diff      = {distance[31], distance} - {last_distance[31], last_distance};
  assign diff_mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;

  edv_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (product)
  );

  edv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next state of the update sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_accept && mode == MODE_UPDATE) state_next = ST_DIST_MUL;
      ST_DIST_MUL: if (mul_done) state_next = ST_DIST_DIV;
      ST_DIST_DIV: if (div_done) state_next = ST_VEL_LOAD;
      ST_VEL_LOAD: state_next = ST_VEL_MUL;
      ST_VEL_MUL:  if (mul_done) state_next = ST_VEL_DIV;
      ST_VEL_DIV:  if (div_done) state_next = ST_HOLD;
      ST_HOLD:     if (slot_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit starts and operand selection
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    neg_load  = 1'b0;
    neg_value = 1'b0;
    mul_a     = steps_mag;
    mul_b     = circumference;
    div_d     = pulses_eff;
    unique case (state)
      ST_IDLE: begin
        mul_start = in_accept && mode == MODE_UPDATE;
        neg_load  = mul_start;
        neg_value = step_count[31];
      end
      ST_DIST_MUL: begin
        div_start = mul_done;
      end
      ST_VEL_LOAD: begin
        mul_start = 1'b1;
        mul_a     = diff_mag;
        mul_b     = MS_PER_SECOND;
        neg_load  = 1'b1;
        neg_value = diff[MAG_W-1];
      end
      ST_VEL_MUL: begin
        div_start = mul_done;
        div_d     = dt_eff;
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      circumference <= 16'd1;
      pulses        <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CIRCUMFERENCE: circumference <= cfg_data;
        REG_PULSES:        pulses        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Step counter: on an edge beat with channel A high, count up, or down when B is high
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (in_accept && mode == MODE_EDGE && pin_a_level) begin
      step_count <= pin_b_level ? step_count - 32'sd1 : step_count + 32'sd1;
    end
  end

  // Hold the elapsed time and the sign of the running computation
  always_ff @(posedge clk) begin
    if (in_accept) dt <= elapsed_ms;
    if (neg_load) neg <= neg_value;
  end

  // Capture distance and velocity as the divider finishes
  always_ff @(posedge clk) begin
    if (state == ST_DIST_DIV && div_done) distance <= sat32(neg, quotient);
    if (state == ST_VEL_DIV && div_done) vel <= sat32(neg, quotient);
  end

  // Last distance and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == ST_HOLD && slot_free) begin
        out_valid     <= 1'b1;
        last_distance <= distance;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && slot_free) begin
      distance_out <= distance;
      velocity_out <= vel;
    end
  end

endmodule

// File: rtl/edv_mul.sv
// Digit-serial unsigned multiplier, four factor bits per cycle.
module edv_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [edv_pkg::MAG_W-1:0]   op_a,
  input  logic [edv_pkg::FACT_W-1:0]  op_b,
  output logic                        done,
  output logic [edv_pkg::PROD_W-1:0]  product
);
  import edv_pkg::*;

  logic [MAG_W-1:0]     a_hold;
  logic [FACT_W-1:0]    b_shift;
  logic [PROD_W-1:0]    acc;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic [PROD_W-1:0]    partial;

  // Add one digit's partial product to the shifted accumulator
  assign partial = PROD_W'(a_hold * b_shift[FACT_W-1 -: MUL_DIGIT]);

  // Control: count the digits, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == MUL_CNT_W'(MUL_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) busy <= 1'b0;
      end
    end
  end

  // Datapath: load operands, then shift in one digit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_hold  <= op_a;
      b_shift <= op_b;
      acc     <= '0;
    end else if (busy) begin
      acc     <= (acc << MUL_DIGIT) + partial;
      b_shift <= b_shift << MUL_DIGIT;
    end
  end

  assign product = acc;

endmodule

// File: rtl/edv_div.sv
// Digit-serial restoring divider, two quotient bits per cycle.
module edv_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [edv_pkg::PROD_W-1:0]  dividend,
  input  logic [edv_pkg::FACT_W-1:0]  divisor,
  output logic                        done,
  output logic [edv_pkg::PROD_W-1:0]  quotient
);
  import edv_pkg::*;

  logic [PROD_W-1:0]    work;
  logic [FACT_W-1:0]    dvs;
  logic [FACT_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [FACT_W:0]      trial_a, trial_b;
  logic                 q_a, q_b;
  logic [FACT_W-1:0]    rem_a, rem_b;

  // Two restoring steps in cascade on the narrow remainder
  always_comb begin
    trial_a = {rem, work[PROD_W-1]};
    q_a     = trial_a >= {1'b0, dvs};
    rem_a   = q_a ? FACT_W'(trial_a - {1'b0, dvs}) : trial_a[FACT_W-1:0];
    trial_b = {rem_a, work[PROD_W-2]};
    q_b     = trial_b >= {1'b0, dvs};
    rem_b   = q_b ? FACT_W'(trial_b - {1'b0, dvs}) : trial_b[FACT_W-1:0];
  end

  // Control: count digit pairs, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) busy <= 1'b0;
      end
    end
  end

  // Datapath: dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[PROD_W-3:0], q_a, q_b};
      rem  <= rem_b;
    end
  end

  assign quotient = work;

endmodule
